FILE: rtl/fiducial_tag_cell_decoder_top_defines.svh
// Assertion macros for the fiducial tag cell decoder.
// Used by fiducial_tag_cell_decoder_top.sv; expects clk and rst in scope.
`ifndef FIDUCIAL_TAG_CELL_DECODER_TOP_DEFINES_SVH
`define FIDUCIAL_TAG_CELL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FTCD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftcd assertion failed");

// Next-cycle implication, disabled during reset.
`define FTCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftcd assertion failed");

`endif

FILE: rtl/ftcd_pkg.sv
// Package for the fiducial tag cell decoder: status codes, register indexes,
// reset values and the grid helper functions. No dependencies.
`default_nettype none

package ftcd_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BORDER    = 3'd1,
    ST_AMBIGUOUS = 3'd2,
    ST_NO_ANCHOR = 3'd3,
    ST_PARITY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_BORDER_DARK_ABOVE   = 2'd0,
    CFG_BORDER_MIN_DARK     = 2'd1,
    CFG_PAYLOAD_DARK_ABOVE  = 2'd2,
    CFG_PAYLOAD_LIGHT_BELOW = 2'd3
  } cfg_index_t;

  localparam logic [3:0] RST_BORDER_DARK_ABOVE   = 4'd4;
  localparam logic [4:0] RST_BORDER_MIN_DARK     = 5'd21;
  localparam logic [3:0] RST_PAYLOAD_DARK_ABOVE  = 4'd5;
  localparam logic [3:0] RST_PAYLOAD_LIGHT_BELOW = 4'd3;

  localparam logic [3:0] FULL_DARK    = 4'd9;
  localparam logic [4:0] BORDER_MAX   = 5'd31;
  localparam logic [4:0] PAYLOAD_CELLS = 5'd16;

  // One clockwise quarter turn of a row-major 4x4 grid.
  function automatic logic [15:0] turn_cw(input logic [15:0] g);
    logic [15:0] r;
    r = '0;
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 4; x++) begin
        r[x * 4 + (3 - y)] = g[y * 4 + x];
      end
    end
    return r;
  endfunction

  // Cell 0 light, the other three corners dark.
  function automatic logic anchor_ok(input logic [15:0] g);
    return g[0] && !g[3] && !g[12] && !g[15];
  endfunction

  // The twelve non-corner cells in row-major order.
  function automatic logic [11:0] data_bits(input logic [15:0] g);
    return {g[14], g[13], g[11], g[10], g[9], g[8],
            g[7], g[6], g[5], g[4], g[2], g[1]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fiducial_tag_cell_decoder_top.sv
// Fiducial tag cell decoder: accumulates border and payload cells and decodes
// a 4x4 tag on the last cell. Depends on ftcd_pkg and the defines header.
//
// Usage: cells enter on the s_ stream, one transaction per cell. s_tdata
// carries the dark-sample count, s_tuser the off-image flag and the cell
// kind, and s_tlast marks the final cell of a candidate tag. Each final cell
// produces exactly one transaction on the m_ stream with the tag id, the
// rotation and a status; other cells produce none.
// Thresholds are written over the cfg_ channel, which is always ready and
// should only be written while no tag is in flight.
// Path: an accepted cell waits in the input register; when a final cell
// retires from it, its decoded result is loaded into the output register,
// which offers it on the m_ stream.
// Throughput: one cell per cycle while no final cell is held back, set by the
// input register feeding the combinational decode into the output register.
// When the receiver stalls, a held result blocks only the next final cell;
// other cells keep flowing, and s_tready drops only when a final cell waits.
// Reset clears the accumulated tag, both valid flags and restores the
// threshold registers to their defaults.
`default_nettype none
`include "fiducial_tag_cell_decoder_top_defines.svh"

module fiducial_tag_cell_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [3:0] dark_samples, [7:4] zero
  input  wire logic [1:0]  s_tuser,   // [0] off_image, [1] cell_kind
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] tag_id, [9:8] rotation,
                                      // [12:10] status, [15:13] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  logic [3:0] border_dark_above;
  logic [4:0] border_min_dark;
  logic [3:0] payload_dark_above;
  logic [3:0] payload_light_below;

  logic       in_valid;
  logic [3:0] in_dark;
  logic       in_kind;
  logic       in_last;

  logic [4:0]  border_dark_total;
  logic [15:0] payload_bits;
  logic [4:0]  payload_index;
  logic        ambiguous_seen;

  logic [4:0]  border_dark_total_next;
  logic [15:0] payload_bits_next;
  logic [4:0]  payload_index_next;
  logic        ambiguous_seen_next;

  logic        out_valid;
  logic [7:0]  out_id;
  logic [1:0]  out_rot;
  ftcd_pkg::status_t out_status;

  logic        retire;
  logic        out_load;
  logic [15:0] grid [4];
  logic [1:0]  sel_rot;
  logic        sel_found;
  logic [15:0] sel_grid;
  logic [11:0] sel_data;
  logic [7:0]  dec_id;
  logic [1:0]  dec_rot;
  ftcd_pkg::status_t dec_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_dark_above   <= ftcd_pkg::RST_BORDER_DARK_ABOVE;
      border_min_dark     <= ftcd_pkg::RST_BORDER_MIN_DARK;
      payload_dark_above  <= ftcd_pkg::RST_PAYLOAD_DARK_ABOVE;
      payload_light_below <= ftcd_pkg::RST_PAYLOAD_LIGHT_BELOW;
    end else if (cfg_valid) begin
      case (ftcd_pkg::cfg_index_t'(cfg_index))
        ftcd_pkg::CFG_BORDER_DARK_ABOVE:   border_dark_above   <= cfg_data[3:0];
        ftcd_pkg::CFG_BORDER_MIN_DARK:     border_min_dark     <= cfg_data;
        ftcd_pkg::CFG_PAYLOAD_DARK_ABOVE:  payload_dark_above  <= cfg_data[3:0];
        ftcd_pkg::CFG_PAYLOAD_LIGHT_BELOW: payload_light_below <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // A buffered cell can always retire unless it is final and the result
  // register is still occupied and m_tready is low.
  assign retire   = in_valid && (!in_last || !out_valid || m_tready);
  assign out_load = retire && in_last;
  assign s_tready = !in_valid || retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_dark <= s_tuser[0] ? ftcd_pkg::FULL_DARK : s_tdata[3:0];
      in_kind <= s_tuser[1];
      in_last <= s_tlast;
    end
  end

  // Accumulate the buffered cell into the tag state.
  always_comb begin
    border_dark_total_next = border_dark_total;
    payload_bits_next      = payload_bits;
    payload_index_next     = payload_index;
    ambiguous_seen_next    = ambiguous_seen;
    if (!in_kind) begin
      if (in_dark > border_dark_above && border_dark_total < ftcd_pkg::BORDER_MAX) begin
        border_dark_total_next = border_dark_total + 5'd1;
      end
    end else if (payload_index < ftcd_pkg::PAYLOAD_CELLS) begin
      if (in_dark > payload_dark_above) begin
        payload_bits_next[payload_index[3:0]] = 1'b0;
      end else if (in_dark < payload_light_below) begin
        payload_bits_next[payload_index[3:0]] = 1'b1;
      end else begin
        ambiguous_seen_next = 1'b1;
      end
      payload_index_next = payload_index + 5'd1;
    end
  end

  always_comb begin
    grid[0] = payload_bits_next;
    for (int r = 1; r < 4; r++) begin
      grid[r] = ftcd_pkg::turn_cw(grid[r - 1]);
    end
  end

  always_comb begin
    sel_found = 1'b1;
    sel_rot   = 2'd0;
    if (ftcd_pkg::anchor_ok(grid[0])) begin
      sel_rot = 2'd0;
    end else if (ftcd_pkg::anchor_ok(grid[1])) begin
      sel_rot = 2'd1;
    end else if (ftcd_pkg::anchor_ok(grid[2])) begin
      sel_rot = 2'd2;
    end else if (ftcd_pkg::anchor_ok(grid[3])) begin
      sel_rot = 2'd3;
    end else begin
      sel_found = 1'b0;
    end
  end

  assign sel_grid = grid[sel_rot];
  assign sel_data = ftcd_pkg::data_bits(sel_grid);

  always_comb begin
    dec_id     = 8'd0;
    dec_rot    = 2'd0;
    dec_status = ftcd_pkg::ST_OK;
    if (border_dark_total_next < border_min_dark) begin
      dec_status = ftcd_pkg::ST_BORDER;
    end else if (ambiguous_seen_next || payload_index_next < ftcd_pkg::PAYLOAD_CELLS) begin
      dec_status = ftcd_pkg::ST_AMBIGUOUS;
    end else if (!sel_found) begin
      dec_status = ftcd_pkg::ST_NO_ANCHOR;
    end else if (sel_data[11:8] != (sel_data[3:0] ^ sel_data[7:4])) begin
      dec_status = ftcd_pkg::ST_PARITY;
    end else begin
      dec_id  = sel_data[7:0];
      dec_rot = sel_rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      border_dark_total <= '0;
      payload_bits      <= '0;
      payload_index     <= '0;
      ambiguous_seen    <= 1'b0;
    end else if (retire) begin
      if (in_last) begin
        border_dark_total <= '0;
        payload_bits      <= '0;
        payload_index     <= '0;
        ambiguous_seen    <= 1'b0;
      end else begin
        border_dark_total <= border_dark_total_next;
        payload_bits      <= payload_bits_next;
        payload_index     <= payload_index_next;
        ambiguous_seen    <= ambiguous_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id     <= dec_id;
      out_rot    <= dec_rot;
      out_status <= dec_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_status, out_rot, out_id};

  `FTCD_ASSERT_IMPL(a_fail_clears_id, out_valid && out_status != ftcd_pkg::ST_OK,
                    out_id == 8'd0 && out_rot == 2'd0)
  `FTCD_ASSERT_IMPL(a_index_bound, 1'b1, payload_index <= ftcd_pkg::PAYLOAD_CELLS)
  `FTCD_ASSERT_NEXT(a_clear_after_last, out_load,
                    payload_index == 5'd0 && border_dark_total == 5'd0 &&
                    !ambiguous_seen && payload_bits == 16'd0)
  `FTCD_ASSERT_NEXT(a_result_from_last, !out_valid && !out_load, !out_valid)

endmodule

`default_nettype wire
